@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros for concurrent properties, empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_AR(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");

`define ASSERT_CLK(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("assertion failed");

`else

`define ASSERT_AR(lbl, clk, rstn, prop)

`define ASSERT_CLK(lbl, clk, prop)

`endif

`endif

@@ sv/b7fs_pkg.sv @@
// ----------------------------------------------------------------------------
// b7fs_pkg
// Shared constants for the Barker-7 frame synchronizer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package b7fs_pkg;

  localparam int unsigned SyncLen  = 7;
  localparam int unsigned SampleW  = 8;
  localparam int unsigned ThrW     = 8;
  localparam int unsigned PatW     = SyncLen;
  localparam int unsigned OffsetW  = 5;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 8;

  localparam logic [ThrW-1:0] ThrRst = 8'd128;
  localparam logic [PatW-1:0] PatRst = 7'd114;

  localparam logic [CfgIdxW-1:0] CfgThreshold   = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgSyncPattern = 2'd1;

endpackage

`default_nettype wire

@@ sv/b7fs_intf.sv @@
// ----------------------------------------------------------------------------
// b7fs_intf
// Valid/ready channels: sample input, result output and register writes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface b7fs_smp_if;
  logic                         valid;
  logic                         ready;
  logic [b7fs_pkg::SampleW-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface b7fs_res_if #(
  parameter int unsigned PAYLOAD_BITS = 17
);
  logic                         valid;
  logic                         ready;
  logic [PAYLOAD_BITS-1:0]      payload;
  logic [b7fs_pkg::OffsetW-1:0] sync_offset;

  modport source (output valid, output payload, output sync_offset, input ready);
  modport sink   (input valid, input payload, input sync_offset, output ready);
endinterface

interface b7fs_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [b7fs_pkg::CfgIdxW-1:0]  index;
  logic [b7fs_pkg::CfgDataW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ sv/b7fs_cell.sv @@
// ----------------------------------------------------------------------------
// b7fs_cell
// One window bit; takes its neighbor's bit on every accepted sample.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module b7fs_cell (
  input  wire  clk_i,
  input  wire  rst_ni,
  input  wire  shift_i,
  input  wire  nbr_i,
  output logic bit_o,
  output logic nxt_o
);

  logic bit_q;
  logic bit_d;

  assign bit_d = shift_i ? nbr_i : bit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_q <= 1'b0;
    end else begin
      bit_q <= bit_d;
    end
  end

  assign bit_o = bit_q;
  assign nxt_o = bit_d;

endmodule

`default_nettype wire

@@ sv/b7fs_search.sv @@
// ----------------------------------------------------------------------------
// b7fs_search
// Sync word search over the window and payload selection.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module b7fs_search #(
  parameter int unsigned BLOCK_LEN    = 25,
  parameter int unsigned PAYLOAD_BITS = 17
) (
  input  wire [2*BLOCK_LEN-1:0]              win_i,
  input  wire [b7fs_pkg::PatW-1:0]           pat_i,
  output logic                               found_o,
  output logic [$clog2(BLOCK_LEN+1)-1:0]     off_o,
  output logic [PAYLOAD_BITS-1:0]            payload_o
);

  localparam int unsigned WinW  = 2 * BLOCK_LEN;
  localparam int unsigned Reach = BLOCK_LEN + b7fs_pkg::SyncLen + PAYLOAD_BITS;
  localparam int unsigned ExtW  = (WinW > Reach) ? WinW : Reach;
  localparam int unsigned OffW  = $clog2(BLOCK_LEN + 1);

  logic [BLOCK_LEN:0] hit;
  logic [ExtW-1:0]    ext;
  logic [ExtW-1:0]    sh;
  logic [OffW:0]      start;

  always_comb begin
    for (int p = 0; p <= int'(BLOCK_LEN); p++) begin
      hit[p] = 1'b1;
      for (int j = 0; j < int'(b7fs_pkg::SyncLen); j++) begin
        if (win_i[p+j] != pat_i[int'(b7fs_pkg::SyncLen) - 1 - j]) begin
          hit[p] = 1'b0;
        end
      end
    end
  end

  // lowest offset wins
  always_comb begin
    found_o = 1'b0;
    off_o   = '0;
    for (int p = int'(BLOCK_LEN); p >= 0; p--) begin
      if (hit[p]) begin
        found_o = 1'b1;
        off_o   = OffW'(p);
      end
    end
  end

  assign ext   = ExtW'(win_i);
  assign start = {1'b0, off_o} + (OffW+1)'(b7fs_pkg::SyncLen);
  assign sh    = ext >> start;

  always_comb begin
    for (int i = 0; i < int'(PAYLOAD_BITS); i++) begin
      payload_o[int'(PAYLOAD_BITS) - 1 - i] = sh[i];
    end
  end

endmodule

`default_nettype wire

@@ sv/barker7_frame_sync_extractor.sv @@
// ----------------------------------------------------------------------------
// barker7_frame_sync_extractor
// Barker-7 frame synchronizer: slices samples, finds sync, extracts payload.
// ----------------------------------------------------------------------------
// Takes one sample per clock cycle with no gaps of its own. Each sample is
// sliced against the threshold and shifted into a row of 2*BLOCK_LEN bit
// cells. On every BLOCK_LEN-th sample the sync search runs on the updated
// window in the accept cycle and a result, if any, appears in the output
// register on the next cycle. The only input stall is a block-completing
// sample that arrives while the output register still holds an untaken
// result; all other samples are accepted regardless of the output side.
// Registers may be written at any time and take effect from the next sample.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module barker7_frame_sync_extractor #(
  parameter int unsigned BLOCK_LEN    = 25,
  parameter int unsigned PAYLOAD_BITS = 17
) (
  input  wire  clk_i,
  input  wire  rst_ni,
  b7fs_smp_if.sink   smp_i,
  b7fs_cfg_if.sink   cfg_i,
  b7fs_res_if.source res_o
);

  localparam int unsigned WinW = 2 * BLOCK_LEN;
  localparam int unsigned CntW = $clog2(BLOCK_LEN);
  localparam int unsigned OffW = $clog2(BLOCK_LEN + 1);
  localparam logic [CntW-1:0] LastIdx = CntW'(BLOCK_LEN - 1);

  logic [b7fs_pkg::ThrW-1:0] thr_q;
  logic [b7fs_pkg::PatW-1:0] pat_q;
  logic [CntW-1:0]           cnt_q, cnt_d;
  logic                      ovld_q, ovld_d;
  logic [PAYLOAD_BITS-1:0]   pay_q;
  logic [b7fs_pkg::OffsetW-1:0] off_q;

  logic            acc, blk_end, slice_bit;
  logic [WinW-1:0] win_q, win_d;
  logic            found;
  logic [OffW-1:0] off;
  logic [PAYLOAD_BITS-1:0] pay;
  logic [OffW+b7fs_pkg::OffsetW-1:0] off_ext;

  assign blk_end     = (cnt_q == LastIdx);
  assign smp_i.ready = !blk_end || !ovld_q || res_o.ready;
  assign acc         = smp_i.valid && smp_i.ready;
  assign slice_bit   = (smp_i.sample > thr_q);

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= b7fs_pkg::ThrRst;
      pat_q <= b7fs_pkg::PatRst;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        b7fs_pkg::CfgThreshold:   thr_q <= cfg_i.data[b7fs_pkg::ThrW-1:0];
        b7fs_pkg::CfgSyncPattern: pat_q <= cfg_i.data[b7fs_pkg::PatW-1:0];
        default: ;
      endcase
    end
  end

  // newest bit enters at the top cell
  for (genvar g = 0; g < WinW; g++) begin : g_cell
    logic nbr;
    if (g == WinW - 1) begin : g_top
      assign nbr = slice_bit;
    end else begin : g_mid
      assign nbr = win_q[g+1];
    end
    b7fs_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (acc),
      .nbr_i   (nbr),
      .bit_o   (win_q[g]),
      .nxt_o   (win_d[g])
    );
  end

  b7fs_search #(
    .BLOCK_LEN    (BLOCK_LEN),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_search (
    .win_i     (win_d),
    .pat_i     (pat_q),
    .found_o   (found),
    .off_o     (off),
    .payload_o (pay)
  );

  assign off_ext = {{b7fs_pkg::OffsetW{1'b0}}, off};

  always_comb begin
    cnt_d  = cnt_q;
    ovld_d = ovld_q && !res_o.ready;
    if (acc) begin
      cnt_d = blk_end ? '0 : cnt_q + CntW'(1);
      if (blk_end && found) begin
        ovld_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      ovld_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      ovld_q <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc && blk_end && found) begin
      pay_q <= pay;
      off_q <= off_ext[b7fs_pkg::OffsetW-1:0];
    end
  end

  assign res_o.valid       = ovld_q;
  assign res_o.payload     = pay_q;
  assign res_o.sync_offset = off_q;

  `ASSERT_AR(a_cnt_range, clk_i, rst_ni, cnt_q <= LastIdx)
  `ASSERT_AR(a_rise_on_blk, clk_i, rst_ni, (acc && !blk_end) |=> !$rose(ovld_q))
  `ASSERT_AR(a_no_overrun, clk_i, rst_ni, (blk_end && ovld_q && !res_o.ready) |-> !smp_i.ready)
  `ASSERT_AR(a_cnt_wrap, clk_i, rst_ni, (acc && blk_end) |=> (cnt_q == '0))

endmodule

`default_nettype wire
